// ===== sv/dfic_pkg.sv =====
// ----------------------------------------------------------------------------
// dfic_pkg: shared types and constants
// field widths, test pattern words, config register indexes and the
// per-word control and per-frame result records
// ----------------------------------------------------------------------------
package dfic_pkg;

    localparam int POS_BITS  = 24;
    localparam int WORD_BITS = 32;
    localparam int ID_BITS   = 64;
    localparam int CNT_BITS  = 32;
    localparam int STEP_BITS = 20;
    localparam int IDX_BITS  = 2;

    localparam logic [POS_BITS-1:0]  POS_MAX      = 24'hffffff;
    localparam logic [WORD_BITS-1:0] FLASH_WORD   = 32'h07ff07ff;
    localparam logic [15:0]          FLASH_SAMPLE = 16'h07ff;
    localparam logic [STEP_BITS-1:0] STEP_RESET   = 20'd910000;

    // header word positions
    localparam logic [POS_BITS-1:0] POS_LENGTH   = 24'd0;
    localparam logic [POS_BITS-1:0] POS_TAG      = 24'd1;
    localparam logic [POS_BITS-1:0] POS_ID_LOW   = 24'd3;
    localparam logic [POS_BITS-1:0] POS_ID_HIGH  = 24'd4;
    localparam logic [POS_BITS-1:0] POS_PAYLOAD  = 24'd8;
    localparam logic [POS_BITS-1:0] POS_SEARCH   = 24'd14;
    localparam logic [POS_BITS-1:0] POS_IL_CHECK = 24'd30;

    localparam logic [3:0] PERIOD_LAST = 4'd10;
    localparam logic [3:0] SEARCH_LEN  = 4'd11;

    // config register indexes
    localparam logic [IDX_BITS-1:0] CFG_INTERLEAVE = 2'd0;
    localparam logic [IDX_BITS-1:0] CFG_LONG_ID    = 2'd1;
    localparam logic [IDX_BITS-1:0] CFG_STEP       = 2'd2;
    localparam logic [IDX_BITS-1:0] CFG_PAT_EN     = 2'd3;

    typedef struct packed {
        logic                 interleave_mode;
        logic                 long_pulse_id;
        logic [STEP_BITS-1:0] pulse_id_step;
        logic                 pattern_check_enable;
    } t_cfg;

    typedef struct packed {
        logic                 fire;
        logic                 last;
        logic [POS_BITS-1:0]  pos;
        logic [WORD_BITS-1:0] word;
    } t_word;

    typedef struct packed {
        logic                is_event;
        logic                dropped_flag;
        logic                repeated_id;
        logic                id_step_error;
        logic                pattern_error;
        logic [CNT_BITS-1:0] event_total;
        logic [CNT_BITS-1:0] drop_total;
        logic [CNT_BITS-1:0] repeat_total;
        logic [CNT_BITS-1:0] corrupt_total;
    } t_result;

endpackage

// ===== sv/dfic_pattern.sv =====
// ----------------------------------------------------------------------------
// dfic_pattern: flash test pattern tracker
// follows phase search and per-sample checks for both payload layouts
// ----------------------------------------------------------------------------
module dfic_pattern #(
    parameter int LENGTH_BITS = 24
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dfic_pkg::t_word i_word,
    input  logic            i_interleave,
    output logic            o_pat_bad
);
    import dfic_pkg::*;

    localparam int PW = LENGTH_BITS - 1;

    typedef struct packed {
        logic          found;
        logic          failed;
        logic [3:0]    off;
        logic [3:0]    modc;
        logic [PW-1:0] cpos;
        logic [2:0]    cidx;
    } t_lin;

    typedef struct packed {
        logic       found;
        logic       failed;
        logic [4:0] off;
        logic       par;
        logic [3:0] modc;
    } t_il;

    localparam t_lin LIN_RESET = '0;
    localparam t_il  IL_RESET  = '0;

    // one 16-bit sample of the four-channel layout
    function automatic t_lin lin_step(input t_lin s, input logic [15:0] v,
                                      input logic [3:0] g, input logic srch,
                                      input logic [PW-1:0] nb);
        t_lin          r;
        logic          chk;
        logic [PW-1:0] offx;
        logic [PW-1:0] p1;
        r   = s;
        chk = s.found;
        if (!s.found && !s.failed && srch) begin
            if (v == FLASH_SAMPLE) begin
                r.found = 1'b1;
                r.off   = g;
                chk     = 1'b1;
            end else if (v != 16'd0) begin
                r.failed = 1'b1;
            end
        end
        offx = {{(PW-4){1'b0}}, r.off};
        if (chk && nb != '0 && r.cidx < 3'd4 && r.cpos >= offx) begin
            if (r.cpos == offx)
                r.modc = 4'd0;
            else
                r.modc = (r.modc >= PERIOD_LAST) ? 4'd0 : r.modc + 4'd1;
            if (v != ((r.modc == 4'd0) ? FLASH_SAMPLE : 16'd0))
                r.failed = 1'b1;
        end
        if (nb != '0) begin
            p1 = r.cpos + 1'b1;
            if (p1 >= nb) begin
                r.cpos = '0;
                if (r.cidx < 3'd4)
                    r.cidx = r.cidx + 3'd1;
            end else begin
                r.cpos = p1;
            end
        end
        return r;
    endfunction

    t_lin                   r_lin, n_lin, lin_base, lin_mid;
    t_il                    r_il, n_il, il_base;
    logic [PW-1:0]          r_nb, n_nb;
    logic [LENGTH_BITS-1:0] r_flen, n_flen;

    logic [LENGTH_BITS-1:0] len_w;
    logic [LENGTH_BITS-1:0] len_m8;
    logic                   is_hdr0;
    logic                   in_pay;
    logic                   srch1, srch2;
    logic [2:0]             kk;
    logic [3:0]             g1, g2;
    logic [4:0]             il_diff;
    logic [3:0]             il_half;
    logic                   cur_par;
    logic [3:0]             cur_mod;
    logic                   k_in_len;

    always_comb begin
        is_hdr0 = (i_word.pos == POS_LENGTH);
        in_pay  = (i_word.pos >= POS_PAYLOAD);
        len_w   = i_word.word[LENGTH_BITS-1:0];
        len_m8  = len_w - LENGTH_BITS'(8);
        n_flen  = is_hdr0 ? len_w : r_flen;
        n_nb    = is_hdr0 ? ((len_w >= LENGTH_BITS'(8)) ? len_m8[LENGTH_BITS-1:1] : '0)
                          : r_nb;

        lin_base = is_hdr0 ? LIN_RESET : r_lin;
        il_base  = is_hdr0 ? IL_RESET : r_il;

        // sample index inside the phase search window
        kk    = 3'(i_word.pos[3:0] - 4'd8);
        g1    = {kk, 1'b0};
        g2    = g1 + 4'd1;
        srch1 = in_pay && (i_word.pos < POS_SEARCH);
        srch2 = srch1 && (g2 < SEARCH_LEN);

        lin_mid = lin_base;
        n_lin   = lin_base;
        if (in_pay) begin
            lin_mid = lin_step(lin_base, i_word.word[15:0], g1, srch1, n_nb);
            n_lin   = lin_step(lin_mid, i_word.word[31:16], g2, srch2, n_nb);
        end

        // interleaved layout: period counter of ((k - s) / 2) mod 11
        il_diff  = 5'd30 - il_base.off;
        il_half  = il_diff[4:1];
        cur_par  = (i_word.pos == POS_IL_CHECK) ? il_diff[0] : il_base.par;
        cur_mod  = (i_word.pos == POS_IL_CHECK) ? ((il_half == SEARCH_LEN) ? 4'd0 : il_half)
                                                : il_base.modc;
        k_in_len = (i_word.pos < {{(POS_BITS-LENGTH_BITS){1'b0}}, n_flen});

        n_il = il_base;
        if (in_pay) begin
            if (i_word.pos < POS_IL_CHECK) begin
                if (!il_base.found && !il_base.failed) begin
                    if (i_word.word == FLASH_WORD) begin
                        n_il.found = 1'b1;
                        n_il.off   = i_word.pos[4:0];
                    end else if (i_word.word != '0) begin
                        n_il.failed = 1'b1;
                    end
                end
            end else begin
                if (il_base.found && k_in_len &&
                    i_word.word != ((cur_mod == 4'd0) ? FLASH_WORD : '0))
                    n_il.failed = 1'b1;
                n_il.par  = ~cur_par;
                n_il.modc = cur_par ? ((cur_mod >= PERIOD_LAST) ? 4'd0 : cur_mod + 4'd1)
                                    : cur_mod;
            end
        end

        o_pat_bad = i_interleave ? (n_il.failed || !n_il.found)
                                 : (n_lin.failed || !n_lin.found);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin <= LIN_RESET;
            r_il  <= IL_RESET;
        end else if (i_word.fire) begin
            r_lin <= n_lin;
            r_il  <= n_il;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_word.fire) begin
            r_nb   <= n_nb;
            r_flen <= n_flen;
        end
    end

endmodule

// ===== sv/dfic_stats.sv =====
// ----------------------------------------------------------------------------
// dfic_stats: header capture, pulse id checks and running counters
// builds one result record at the last word of each frame
// ----------------------------------------------------------------------------
module dfic_stats (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dfic_pkg::t_word   i_word,
    input  dfic_pkg::t_cfg    i_cfg,
    input  logic              i_pat_bad,
    output logic              o_res_valid,
    output dfic_pkg::t_result o_res
);
    import dfic_pkg::*;

    logic               r_tag_zero, n_tag_zero;
    logic               r_tag_drop, n_tag_drop;
    logic [ID_BITS-1:0] r_cur_id, n_cur_id;
    logic [ID_BITS-1:0] r_prev_id, n_prev_id;
    logic               r_ref_valid, n_ref_valid;
    logic [CNT_BITS-1:0] r_ev_cnt, n_ev_cnt;
    logic [CNT_BITS-1:0] r_drop_cnt, n_drop_cnt;
    logic [CNT_BITS-1:0] r_rep_cnt, n_rep_cnt;
    logic [CNT_BITS-1:0] r_cor_cnt, n_cor_cnt;

    logic [ID_BITS-1:0] pid;
    logic [ID_BITS-1:0] id_diff;
    logic               ev, drop, rep, stp, pat;

    always_comb begin
        n_tag_zero = r_tag_zero;
        n_tag_drop = r_tag_drop;
        n_cur_id   = r_cur_id;
        case (i_word.pos)
            POS_LENGTH: begin
                n_tag_zero = 1'b1;
                n_tag_drop = 1'b0;
                n_cur_id   = '0;
            end
            POS_TAG: begin
                n_tag_zero = (i_word.word[15:0] == 16'd0);
                n_tag_drop = i_word.word[30];
            end
            POS_ID_LOW:  n_cur_id[31:0]  = i_word.word;
            POS_ID_HIGH: n_cur_id[63:32] = i_word.word;
            default: ;
        endcase

        pid     = i_cfg.long_pulse_id ? n_cur_id : {32'd0, n_cur_id[63:32]};
        id_diff = pid - r_prev_id;

        ev   = 1'b0;
        drop = 1'b0;
        rep  = 1'b0;
        stp  = 1'b0;
        pat  = 1'b0;
        n_ref_valid = r_ref_valid;
        n_prev_id   = r_prev_id;
        n_ev_cnt    = r_ev_cnt;
        n_drop_cnt  = r_drop_cnt;
        n_rep_cnt   = r_rep_cnt;
        n_cor_cnt   = r_cor_cnt;

        if (i_word.last) begin
            if (!r_ref_valid) begin
                // first event frame only sets the reference id
                if (n_tag_zero) begin
                    n_ev_cnt    = r_ev_cnt + 1'b1;
                    n_prev_id   = pid;
                    n_ref_valid = 1'b1;
                end
            end else begin
                drop = n_tag_drop;
                if (n_tag_zero) begin
                    ev   = 1'b1;
                    rep  = (pid == r_prev_id);
                    stp  = !rep && (id_diff != {{(ID_BITS-STEP_BITS){1'b0}},
                                                i_cfg.pulse_id_step});
                    pat  = i_cfg.pattern_check_enable && i_pat_bad;
                    n_prev_id = pid;
                end
                n_ev_cnt   = r_ev_cnt + {31'd0, ev};
                n_drop_cnt = r_drop_cnt + {31'd0, drop};
                n_rep_cnt  = r_rep_cnt + {31'd0, rep};
                n_cor_cnt  = r_cor_cnt + {30'd0, stp & pat, stp ^ pat};
            end
        end

        o_res_valid         = i_word.fire && i_word.last;
        o_res.is_event      = ev;
        o_res.dropped_flag  = drop;
        o_res.repeated_id   = rep;
        o_res.id_step_error = stp;
        o_res.pattern_error = pat;
        o_res.event_total   = n_ev_cnt;
        o_res.drop_total    = n_drop_cnt;
        o_res.repeat_total  = n_rep_cnt;
        o_res.corrupt_total = n_cor_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_valid <= 1'b0;
            r_prev_id   <= '0;
            r_ev_cnt    <= '0;
            r_drop_cnt  <= '0;
            r_rep_cnt   <= '0;
            r_cor_cnt   <= '0;
        end else if (i_word.fire) begin
            r_ref_valid <= n_ref_valid;
            r_prev_id   <= n_prev_id;
            r_ev_cnt    <= n_ev_cnt;
            r_drop_cnt  <= n_drop_cnt;
            r_rep_cnt   <= n_rep_cnt;
            r_cor_cnt   <= n_cor_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_word.fire) begin
            r_tag_zero <= n_tag_zero;
            r_tag_drop <= n_tag_drop;
            r_cur_id   <= n_cur_id;
        end
    end

endmodule

// ===== sv/dfic_out_buf.sv =====
// ----------------------------------------------------------------------------
// dfic_out_buf: result output register with skid stage
// two entries so the producer sees a registered space flag
// ----------------------------------------------------------------------------
module dfic_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dfic_pkg::t_result i_data,
    output logic              o_space,
    output logic              o_valid,
    output dfic_pkg::t_result o_data,
    input  logic              i_ready
);
    import dfic_pkg::*;

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    logic    take;

    assign take    = r_out_valid && i_ready;
    assign o_space = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            if (!r_out_valid)
                r_out_valid <= 1'b1;
            else
                r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end else if (i_push) begin
            if (!r_out_valid)
                r_out <= i_data;
            else
                r_skid <= i_data;
        end
    end

endmodule

// ===== sv/dma_frame_integrity_checker_top.sv =====
// ----------------------------------------------------------------------------
// dma_frame_integrity_checker_top: digitizer dma frame checker
// checks headers, pulse ids and the flash test pattern of dma frames
// ----------------------------------------------------------------------------
// Takes one 32-bit frame word per clock when not stalled on the slave stream
// (tlast marks the final word) and gives one result item per frame on the
// master stream. Each word is held in the input register, then passes the
// header, pulse id and pattern logic into the frame state and result
// registers, where its effect on the frame state is settled. Sustained rate
// is one word per clock; words keep flowing while a result waits, and the
// slave side stalls only when two finished results are unread, since the
// output register plus its skid entry hold exactly two. Config registers are
// written through a plain write port and take effect at once; write them only
// while no frame is in flight. The first frame whose tag low half is zero
// becomes the pulse id reference; frames before it give all-zero flags.
// ----------------------------------------------------------------------------
module dma_frame_integrity_checker_top #(
    parameter int LENGTH_BITS = 24
) (
    input  logic           i_clk,
    input  logic           i_rst_n,

    // slave stream: tdata = frame_word[31:0]
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  logic [31:0]    i_s_tdata,     // frame_word
    input  logic           i_s_tlast,     // last_word

    // master stream: tdata from bit 0 up = is_event, dropped_flag,
    // repeated_id, id_step_error, pattern_error, event_total[31:0],
    // drop_total[31:0], repeat_total[31:0], corrupt_total[31:0], zero pad
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    output logic [135:0]   o_m_tdata,

    // config write port
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [19:0]    i_cfg_data
);
    import dfic_pkg::*;

    // config registers
    t_cfg r_cfg;

    // input register
    logic                 r_in_valid;
    logic [WORD_BITS-1:0] r_in_word;
    logic                 r_in_last;

    // word position within the frame, saturating
    logic [POS_BITS-1:0] r_pos, n_pos;

    logic    space;
    logic    fire;
    logic    accept;
    t_word   cur_word;
    logic    pat_bad;
    logic    res_valid;
    t_result res;
    t_result out_res;

    // a last word needs room in the output buffer, other words never stall
    assign fire   = r_in_valid && (!r_in_last || space);
    assign accept = i_s_tvalid && o_s_tready;
    assign o_s_tready = !r_in_valid || fire;

    always_comb begin
        cur_word.fire = fire;
        cur_word.last = r_in_last;
        cur_word.pos  = r_pos;
        cur_word.word = r_in_word;
        if (r_in_last)
            n_pos = '0;
        else if (r_pos < POS_MAX)
            n_pos = r_pos + 1'b1;
        else
            n_pos = r_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.interleave_mode      <= 1'b0;
            r_cfg.long_pulse_id        <= 1'b1;
            r_cfg.pulse_id_step        <= STEP_RESET;
            r_cfg.pattern_check_enable <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INTERLEAVE: r_cfg.interleave_mode      <= i_cfg_data[0];
                CFG_LONG_ID:    r_cfg.long_pulse_id        <= i_cfg_data[0];
                CFG_STEP:       r_cfg.pulse_id_step        <= i_cfg_data;
                CFG_PAT_EN:     r_cfg.pattern_check_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_pos      <= '0;
        end else begin
            if (accept)
                r_in_valid <= 1'b1;
            else if (fire)
                r_in_valid <= 1'b0;
            if (fire)
                r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_word <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    // pattern phase and sample checks for both layouts
    dfic_pattern #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_pattern (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_word       (cur_word),
        .i_interleave (r_cfg.interleave_mode),
        .o_pat_bad    (pat_bad)
    );

    // header capture, id checks and counters
    dfic_stats u_stats (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word      (cur_word),
        .i_cfg       (r_cfg),
        .i_pat_bad   (pat_bad),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result register and skid entry
    dfic_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_space (space),
        .o_valid (o_m_tvalid),
        .o_data  (out_res),
        .i_ready (i_m_tready)
    );

    assign o_m_tdata = {3'd0,
                        out_res.corrupt_total,
                        out_res.repeat_total,
                        out_res.drop_total,
                        out_res.event_total,
                        out_res.pattern_error,
                        out_res.id_step_error,
                        out_res.repeated_id,
                        out_res.dropped_flag,
                        out_res.is_event};

endmodule

// ===== dv/tb_dma_frame_integrity_checker_top.sv =====
// ----------------------------------------------------------------------------
// tb_dma_frame_integrity_checker_top: frame checker testbench
// streams dma frames (directed table, then random frames over several
// register settings) with random idles on both streams, predicts each
// per-frame result item and compares it field by field
// ----------------------------------------------------------------------------
module tb_dma_frame_integrity_checker_top;
    import dfic_pkg::*;

    // one queued stream item, with an optional hand-typed result on its last word
    typedef struct {
        logic [31:0] word;
        bit          last;
        bit          typed;
        t_result     want;
    } frame_item_t;

    // one directed frame; flags are is_event, dropped, repeated, step error,
    // pattern error from high bit down
    typedef struct {
        logic [31:0] hdr;
        logic [31:0] tag;
        logic [31:0] id_lo;
        logic [31:0] id_hi;
        int          n_words;
        bit          typed;
        logic [4:0]  flags;
        int unsigned ev_cnt;
        int unsigned drop_cnt;
        int unsigned rep_cnt;
        int unsigned bad_cnt;
    } frame_row_t;

    logic           i_clk      = 1'b0;
    logic           i_rst_n    = 1'b0;
    logic           i_s_tvalid = 1'b0;
    logic           o_s_tready;
    logic [31:0]    i_s_tdata  = '0;
    logic           i_s_tlast  = 1'b0;
    logic           o_m_tvalid;
    logic           i_m_tready = 1'b0;
    logic [135:0]   o_m_tdata;
    logic           i_cfg_we   = 1'b0;
    logic [1:0]     i_cfg_idx  = CFG_INTERLEAVE;
    logic [19:0]    i_cfg_data = '0;

    dma_frame_integrity_checker_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // frame tracker: shadow of the checker state, reset values as declared
    // ------------------------------------------------------------------------
    bit                   c_interleave = 1'b0;
    bit                   c_long_id    = 1'b1;
    logic [STEP_BITS-1:0] c_step       = STEP_RESET;
    bit                   c_pat_en     = 1'b1;

    logic [23:0]  f_pos      = '0;
    logic [23:0]  f_len      = '0;
    logic [31:0]  f_tag      = '0;
    logic [63:0]  f_cur_id   = '0;
    logic [63:0]  f_prev_id  = '0;
    bit           f_ref_ok   = 1'b0;
    // four-channel layout tracking
    bit           lin_found  = 1'b0;
    bit           lin_fail   = 1'b0;
    int unsigned  lin_off    = 0;
    int unsigned  lin_mod    = 0;
    int unsigned  lin_chpos  = 0;
    int unsigned  lin_chan   = 0;
    // interleaved layout tracking
    bit           il_found   = 1'b0;
    bit           il_fail    = 1'b0;
    int unsigned  il_off     = 0;
    logic [31:0]  run_totals [4] = '{32'd0, 32'd0, 32'd0, 32'd0};

    // one 16-bit sample of the four-channel layout at global sample index g
    function automatic void flash_sample(input logic [15:0] v, input int unsigned g);
        int unsigned nb;
        bit          chk;
        nb  = (f_len >= 24'd8) ? (32'(f_len) - 8) >> 1 : 0;
        chk = lin_found;
        // phase search over the first eleven samples
        if (!lin_found && !lin_fail && g < 11) begin
            if (v == FLASH_SAMPLE) begin
                lin_found = 1'b1;
                lin_off   = g;
                chk       = 1'b1;
            end else if (v != 16'h0) begin
                lin_fail = 1'b1;
            end
        end
        if (chk && nb != 0 && lin_chan < 4 && lin_chpos >= lin_off) begin
            if (lin_chpos == lin_off)
                lin_mod = 0;
            else
                lin_mod = (lin_mod >= 10) ? 0 : lin_mod + 1;
            if (v != ((lin_mod == 0) ? FLASH_SAMPLE : 16'h0))
                lin_fail = 1'b1;
        end
        if (nb != 0) begin
            lin_chpos++;
            if (lin_chpos >= nb) begin
                lin_chpos = 0;
                if (lin_chan < 4)
                    lin_chan++;
            end
        end
    endfunction

    // advance on one accepted word; returns 1 with the frame result on the last word
    function automatic bit frame_word_step(input logic [31:0] w, input bit lst,
                                           output t_result r);
        logic [23:0] k;
        logic [63:0] pid;
        bit          zero_tag;
        int unsigned d;
        k = f_pos;
        r = '0;
        if (k == POS_LENGTH) begin
            f_len     = w[23:0];
            f_tag     = '0;
            f_cur_id  = '0;
            lin_found = 1'b0;
            lin_fail  = 1'b0;
            lin_off   = 0;
            lin_mod   = 0;
            lin_chpos = 0;
            lin_chan  = 0;
            il_found  = 1'b0;
            il_fail   = 1'b0;
            il_off    = 0;
        end else if (k == POS_TAG) begin
            f_tag = w;
        end else if (k == POS_ID_LOW) begin
            f_cur_id[31:0] = w;
        end else if (k == POS_ID_HIGH) begin
            f_cur_id[63:32] = w;
        end else if (k >= POS_PAYLOAD) begin
            flash_sample(w[15:0], (32'(k) - 8) << 1);
            flash_sample(w[31:16], ((32'(k) - 8) << 1) + 1);
            if (k < POS_IL_CHECK) begin
                if (!il_found && !il_fail) begin
                    if (w == FLASH_WORD) begin
                        il_found = 1'b1;
                        il_off   = 32'(k);
                    end else if (w != 32'h0) begin
                        il_fail = 1'b1;
                    end
                end
            end else if (il_found && k < f_len) begin
                d = ((32'(k) - il_off) >> 1) % 11;
                if (w != ((d == 0) ? FLASH_WORD : 32'h0))
                    il_fail = 1'b1;
            end
        end
        if (f_pos != POS_MAX)
            f_pos = f_pos + 24'd1;
        if (!lst)
            return 1'b0;
        f_pos = '0;

        pid      = c_long_id ? f_cur_id : {32'h0, f_cur_id[63:32]};
        zero_tag = (f_tag[15:0] == 16'h0);
        if (!f_ref_ok) begin
            // first event-tagged frame only sets the pulse id reference
            if (zero_tag) begin
                run_totals[0]++;
                f_prev_id = pid;
                f_ref_ok  = 1'b1;
            end
        end else begin
            if (f_tag[30]) begin
                r.dropped_flag = 1'b1;
                run_totals[1]++;
            end
            if (zero_tag) begin
                r.is_event = 1'b1;
                run_totals[0]++;
                if (pid == f_prev_id) begin
                    r.repeated_id = 1'b1;
                    run_totals[2]++;
                end else if (pid - f_prev_id != 64'(c_step)) begin
                    r.id_step_error = 1'b1;
                    run_totals[3]++;
                end
                if (c_pat_en) begin
                    r.pattern_error = c_interleave ? (il_fail || !il_found)
                                                   : (lin_fail || !lin_found);
                    if (r.pattern_error)
                        run_totals[3]++;
                end
                f_prev_id = pid;
            end
        end
        r.event_total   = run_totals[0];
        r.drop_total    = run_totals[1];
        r.repeat_total  = run_totals[2];
        r.corrupt_total = run_totals[3];
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // slave side driver: pops queued words, random idle bursts between items
    // ------------------------------------------------------------------------
    frame_item_t word_q[$];
    frame_item_t cur_item;
    t_result     reports_due[$];
    t_result     pred;
    int          src_gap  = 0;
    int          sink_gap = 0;
    bit          calm     = 1'b0;
    int          n_fail   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            // item accepted at this edge: run it through the tracker
            if (i_s_tvalid && o_s_tready) begin
                if (frame_word_step(cur_item.word, cur_item.last, pred))
                    reports_due.push_back(cur_item.typed ? cur_item.want : pred);
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (word_q.size() != 0) begin
                    cur_item = word_q.pop_front();
                    i_s_tdata  <= cur_item.word;
                    i_s_tlast  <= cur_item.last;
                    i_s_tvalid <= 1'b1;
                    if (!calm && $urandom_range(0, 7) == 0)
                        src_gap = $urandom_range(1, 12);
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // master side: random stall bursts, compare each result item
    // ------------------------------------------------------------------------
    t_result     want_r;
    logic [31:0] want_f [9];
    logic [31:0] got_f  [9];
    string       field_name [9] = '{"is_event", "dropped_flag", "repeated_id",
                                    "id_step_error", "pattern_error", "event_total",
                                    "drop_total", "repeat_total", "corrupt_total"};

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (reports_due.size() == 0) begin
                    $error("result item with no frame pending: %h", o_m_tdata);
                    n_fail++;
                end else begin
                    want_r = reports_due.pop_front();
                    want_f = '{want_r.is_event, want_r.dropped_flag, want_r.repeated_id,
                               want_r.id_step_error, want_r.pattern_error,
                               want_r.event_total, want_r.drop_total,
                               want_r.repeat_total, want_r.corrupt_total};
                    got_f  = '{o_m_tdata[0], o_m_tdata[1], o_m_tdata[2], o_m_tdata[3],
                               o_m_tdata[4], o_m_tdata[36:5], o_m_tdata[68:37],
                               o_m_tdata[100:69], o_m_tdata[132:101]};
                    for (int i = 0; i < 9; i++) begin
                        if (got_f[i] !== want_f[i]) begin
                            $error("%s: expected %0h, got %0h", field_name[i],
                                   want_f[i], got_f[i]);
                            n_fail++;
                        end
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0)
                    sink_gap = $urandom_range(1, 12);
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // builds one frame: header words as given, payload in the chosen layout
    // with the flash pattern at the given phase, optional noise or bit flip
    task automatic queue_frame(input logic [31:0] hdr, input logic [31:0] tag,
                               input logic [31:0] id_lo, input logic [31:0] id_hi,
                               input int n, input bit layout_il, input int unsigned phase,
                               input bit noise, input int flip_pos,
                               input logic [31:0] flip_mask, input bit typed,
                               input t_result want);
        frame_item_t it;
        logic [31:0] w;
        int unsigned nb;
        int unsigned g;
        bit          s;
        nb = (hdr[23:0] >= 24'd8) ? (32'(hdr[23:0]) - 8) >> 1 : 0;
        for (int k = 0; k < n; k++) begin
            case (k)
                0: w = hdr;
                1: w = tag;
                3: w = id_lo;
                4: w = id_hi;
                default: begin
                    if (k < 8 || noise) begin
                        w = $urandom();
                    end else if (layout_il) begin
                        w = (k >= phase && ((k - phase) >> 1) % 11 == 0) ? FLASH_WORD
                                                                         : 32'h0;
                    end else begin
                        for (int h = 0; h < 2; h++) begin
                            g = (k - 8) * 2 + h;
                            if (nb == 0)
                                s = (g == phase);
                            else
                                s = (g / nb < 4) && (g % nb >= phase) &&
                                    ((g % nb - phase) % 11 == 0);
                            w[16*h +: 16] = s ? FLASH_SAMPLE : 16'h0;
                        end
                    end
                end
            endcase
            if (k == flip_pos)
                w = w ^ flip_mask;
            it.word  = w;
            it.last  = (k == n - 1);
            it.typed = typed;
            it.want  = want;
            word_q.push_back(it);
        end
    endtask

    // writes all four registers back to back; upper data bits are don't-care
    // for the one-bit registers and get random values
    task automatic write_config(input bit il, input bit lng, input logic [19:0] step,
                                input bit pe);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_INTERLEAVE;
        i_cfg_data <= {19'($urandom()), il};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_LONG_ID;
        i_cfg_data <= {19'($urandom()), lng};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_STEP;
        i_cfg_data <= step;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_PAT_EN;
        i_cfg_data <= {19'($urandom()), pe};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        c_interleave = il;
        c_long_id    = lng;
        c_step       = step;
        c_pat_en     = pe;
    endtask

    // every queued word accepted and every result item back, then let the
    // two-stage pipe settle
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (word_q.size() != 0 || i_s_tvalid || reports_due.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    frame_row_t dir_rows [8];

    initial begin
        t_result     want;
        logic [31:0] hdr, tag, id_lo, id_hi, mask;
        logic [63:0] gen_pid, tgt, seen;
        logic [23:0] len;
        int          n, pick, flip, words_in_phase;
        int unsigned phase, nb;
        bit          lay, ev;
        bit          p_il, p_long, p_pe;
        logic [19:0] p_step;

        // directed frames under reset settings (four-channel layout, long ids,
        // step 910000, pattern check on)
        dir_rows = '{
            // tag low half nonzero before any reference: all zero
            '{32'd5, 32'h0000_0001, 32'h0, 32'h0, 2, 1'b1, 5'b00000, 0, 0, 0, 0},
            // single-word frame: missing tag reads zero, becomes the reference
            '{32'd1, 32'h0, 32'h0, 32'h0, 1, 1'b1, 5'b00000, 1, 0, 0, 0},
            // drop flag on a non-event frame
            '{32'd2, 32'h4000_ffff, 32'h0, 32'h0, 2, 1'b1, 5'b01000, 1, 1, 0, 0},
            // clean event, id one step on, smallest pattern payload
            '{32'd10, 32'h0, 32'd910000, 32'h0, 10, 1'b1, 5'b10000, 2, 1, 0, 0},
            // same id again: repeated
            '{32'd10, 32'h0, 32'd910000, 32'h0, 10, 1'b1, 5'b10100, 3, 1, 1, 0},
            // all-ones id and no payload: step and pattern error together
            '{32'd5, 32'h0, 32'hffff_ffff, 32'hffff_ffff, 5, 1'b1, 5'b10011, 4, 1, 1, 2},
            // maximum length field, id wraps through zero, frame cut short
            '{32'hffff_ffff, 32'hbfff_0000, 32'd909999, 32'h0, 10, 1'b0, 5'b0, 0, 0, 0, 0},
            // zero length, drop plus event, id words missing
            '{32'h0, 32'h4000_0000, 32'h0, 32'h0, 3, 1'b0, 5'b0, 0, 0, 0, 0}
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        foreach (dir_rows[r]) begin
            want = '{dir_rows[r].flags[4], dir_rows[r].flags[3], dir_rows[r].flags[2],
                     dir_rows[r].flags[1], dir_rows[r].flags[0],
                     32'(dir_rows[r].ev_cnt), 32'(dir_rows[r].drop_cnt),
                     32'(dir_rows[r].rep_cnt), 32'(dir_rows[r].bad_cnt)};
            queue_frame(dir_rows[r].hdr, dir_rows[r].tag, dir_rows[r].id_lo,
                        dir_rows[r].id_hi, dir_rows[r].n_words, 1'b0, 0, 1'b0, -1,
                        32'h0, dir_rows[r].typed, want);
        end
        wait_idle();
        // last directed frame was an event with no id words: reference is zero
        gen_pid = '0;

        // random frames over eight register settings, extremes first
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin p_il = 1; p_long = 1; p_step = STEP_RESET;   p_pe = 1; end
                1: begin p_il = 0; p_long = 0; p_step = 20'd0;        p_pe = 1; end
                2: begin p_il = 1; p_long = 0; p_step = 20'hfffff;    p_pe = 0; end
                3: begin p_il = 0; p_long = 1; p_step = 20'd1;        p_pe = 1; end
                default: begin
                    p_il   = $urandom_range(0, 1);
                    p_long = $urandom_range(0, 1);
                    p_step = 20'($urandom());
                    p_pe   = ($urandom_range(0, 3) != 0);
                end
            endcase
            write_config(p_il, p_long, p_step, p_pe);
            // no idling on either side in the last stretch
            calm = (ph == 7);

            words_in_phase = 0;
            while (words_in_phase < 150) begin
                // length: mostly short frames, some below the payload start,
                // a few long ones
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    len = 24'($urandom_range(0, 7));
                else if (pick < 15)
                    len = 24'($urandom_range(49, 300));
                else
                    len = 24'($urandom_range(8, 48));
                hdr = {($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'h0, len};
                if ($urandom_range(0, 4) != 0)
                    n = (len == 0) ? 1 : int'(len);
                else
                    n = $urandom_range(1, int'(len) + 8);

                // tag: mostly events, drop flag now and then
                if ($urandom_range(0, 4) != 0) begin
                    tag = {$urandom_range(0, 1) == 1, $urandom_range(0, 9) == 0,
                           14'($urandom()), 16'h0};
                end else begin
                    tag = $urandom();
                    if (tag[15:0] == 16'h0)
                        tag[0] = 1'b1;
                end

                // pulse id: mostly the next step, sometimes repeated or random
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    tgt = gen_pid + 64'(c_step);
                else if (pick < 8)
                    tgt = gen_pid;
                else
                    tgt = {$urandom(), $urandom()};
                if (c_long_id) begin
                    {id_hi, id_lo} = tgt;
                end else begin
                    id_hi = tgt[31:0];
                    id_lo = $urandom();
                end

                // payload layout and phase
                lay = ($urandom_range(0, 9) == 0) ? !c_interleave : c_interleave;
                nb  = (len >= 24'd8) ? (32'(len) - 8) >> 1 : 0;
                if (lay)
                    phase = $urandom_range(8, 29);
                else if (nb != 0 && nb <= 10 && $urandom_range(0, 3) != 0)
                    phase = $urandom_range(0, nb - 1);
                else
                    phase = $urandom_range(0, 10);

                // occasional single-bit or whole-word damage
                flip = -1;
                mask = 32'h0;
                if ($urandom_range(0, 6) == 0) begin
                    flip = $urandom_range(0, n - 1);
                    mask = ($urandom_range(0, 1) == 0) ? 32'h1 << $urandom_range(0, 31)
                                                       : $urandom();
                end

                queue_frame(hdr, tag, id_lo, id_hi, n, lay, phase,
                            $urandom_range(0, 19) == 0, flip, mask, 1'b0, '0);

                // follow the id the checker will actually see
                seen = {(n > 4) ? id_hi : 32'h0, (n > 3) ? id_lo : 32'h0};
                if (flip == 3)
                    seen[31:0] = seen[31:0] ^ mask;
                if (flip == 4)
                    seen[63:32] = seen[63:32] ^ mask;
                ev = (n > 1) ? ((flip == 1 ? tag ^ mask : tag) & 32'hffff) == 0 : 1'b1;
                if (ev)
                    gen_pid = c_long_id ? seen : {32'h0, seen[63:32]};
                words_in_phase += n;
            end
            wait_idle();
        end

        repeat (16) @(posedge i_clk);
        if (n_fail == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog
    initial begin
        #5000000;
        $display("simulation failed");
        $finish;
    end

endmodule
